// ----- rtl/core/swm_pkg.sv -----
// Package for the suitor weighted matching block.
// Sizes, field widths and item codes; used by suitor_weighted_matching and the tb files.
package swm_pkg;
	localparam int MAX_VERTICES = 1023;
	localparam int MAX_SLOTS    = 8192;
	localparam int VW = 10;   // vertex id width
	localparam int XW = 11;   // row offset index width
	localparam int OW = 14;   // offset width
	localparam int SW = 13;   // slot width
	localparam int WW = 32;   // weight width
	localparam int ROW_DEPTH = MAX_VERTICES + 2;
	localparam int SUIT_DEPTH = MAX_VERTICES + 1;

	typedef enum logic [1:0] {
		FN_ROW   = 2'd0,
		FN_EDGE  = 2'd1,
		FN_RUN   = 2'd2,
		FN_QUERY = 2'd3
	} func_t;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_ERR = 1'b1;
endpackage

// ----- rtl/core/swm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swm_ram #(
	parameter int DW = 32,
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/suitor_weighted_matching.sv -----
// Suitor weighted matching top level: control sequencer, APB register, three RAMs.
// Depends on swm_pkg and swm_ram.
//
// Half-approximate maximum weight matching by the Suitor scheme. Load beats
// (func 0, 1) fill the row offset and edge RAMs and return a status beat; a query
// beat (func 3) for a bad vertex gets an error status, one in range reads the suitor
// RAM and answers from S_QRY. A run beat (func 2) first sweeps all 1024 suitor
// RAM entries to zero, one entry a cycle, then walks vertices 1..vertex_count.
// Each list scan fetches its bounds from the row RAM in S_ROW0, S_ROW1 and S_ROW2,
// then per edge slot does one edge RAM read and one suitor RAM read (S_EDGE,
// S_EWAIT, S_SWAIT; a slot with a bad neighbor skips S_SWAIT), then closes the
// scan in S_EDGE and commits a proposal in S_PROP; the reply is loaded from
// S_DONE after the last scan. Run time is therefore data dependent; displaced
// suitors rescan their lists. After reset the same sweep runs before the first
// beat is taken. One beat is in flight at a time; the result sits in an output
// register, and the next beat is taken in the cycle that register empties or is
// taken by the receiver. vertex_count is written through APB at addresses 0 to 3.
module suitor_weighted_matching (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [swm_pkg::XW-1:0]   vertex,
	input  logic [swm_pkg::OW-1:0]   offset,
	input  logic [swm_pkg::SW-1:0]   slot,
	input  logic [swm_pkg::VW-1:0]   neighbor,
	input  logic [swm_pkg::WW-1:0]   weight,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     status,
	output logic [swm_pkg::VW-1:0]   suitor,
	output logic [swm_pkg::WW-1:0]   suitor_weight
);
	import swm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_ROW0, S_ROW1, S_ROW2, S_EDGE, S_EWAIT, S_SWAIT,
		S_PROP, S_QRY, S_DONE
	} state_t;

	state_t          state_q;
	logic [VW-1:0]   vc_q;
	logic [VW-1:0]   clr_q;
	logic            run_pend_q;
	logic [VW-1:0]   x_q, cur_q, qv_q;
	logic [OW-1:0]   j_q, end_q;
	logic            found_q;
	logic [WW-1:0]   best_q, bsw_q, ew_q;
	logic [VW-1:0]   partner_q, bsv_q, ey_q;
	logic            out_valid_q, status_q;
	logic [VW-1:0]   suitor_q;
	logic [WW-1:0]   sweight_q;

	// APB: single register
	assign pready = 1'b1;
	assign prdata = {{(32-VW){1'b0}}, vc_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= '0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			vc_q <= pwdata[VW-1:0];
		end
	end

	// beat handshake
	logic out_free, accept;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign suitor    = suitor_q;
	assign suitor_weight = sweight_q;

	// query in range, and any beat that loads the result register this cycle
	logic q_ok, res_load;
	assign q_ok = (vertex != '0) && (vertex <= {1'b0, vc_q});
	assign res_load = (accept && (func != FN_RUN) && !((func == FN_QUERY) && q_ok)) ||
		(((state_q == S_QRY) || (state_q == S_DONE)) && out_free);

	// RAMs
	logic              row_we;
	logic [XW-1:0]     row_raddr;
	logic [OW-1:0]     row_rdata;
	logic              edge_we;
	logic [VW+WW-1:0]  edge_rdata;
	logic              suit_we;
	logic [VW-1:0]     suit_waddr, suit_raddr;
	logic [VW+WW-1:0]  suit_wdata, suit_rdata;

	logic row_ok;
	assign row_ok = (vertex <= XW'(MAX_VERTICES + 1)) && (offset <= OW'(MAX_SLOTS));
	assign row_we  = accept && (func == FN_ROW) && row_ok;
	assign edge_we = accept && (func == FN_EDGE);

	assign row_raddr = (state_q == S_ROW0) ? {1'b0, cur_q} : ({1'b0, cur_q} + XW'(1));

	logic [VW-1:0] e_y, s_sv;
	logic [WW-1:0] e_w, s_sw;
	assign e_y  = edge_rdata[VW+WW-1:WW];
	assign e_w  = edge_rdata[WW-1:0];
	assign s_sv = suit_rdata[VW+WW-1:WW];
	assign s_sw = suit_rdata[WW-1:0];

	always_comb begin
		case (state_q)
			S_IDLE:  suit_raddr = vertex[VW-1:0];
			S_QRY:   suit_raddr = qv_q;
			default: suit_raddr = e_y;
		endcase
	end

	// proposal decision at the end of a scan
	logic win;
	assign win = found_q && (best_q != '0) &&
		((best_q > bsw_q) || ((best_q == bsw_q) && (cur_q > bsv_q)));

	assign suit_we    = (state_q == S_CLR) || ((state_q == S_PROP) && win);
	assign suit_waddr = (state_q == S_CLR) ? clr_q : partner_q;
	assign suit_wdata = (state_q == S_CLR) ? '0 : {cur_q, best_q};

	swm_ram #(.DW(OW), .DEPTH(ROW_DEPTH)) u_row (
		.clk(clk), .we(row_we), .waddr(vertex), .wdata(offset),
		.raddr(row_raddr), .rdata(row_rdata)
	);
	swm_ram #(.DW(VW+WW), .DEPTH(MAX_SLOTS)) u_edge (
		.clk(clk), .we(edge_we), .waddr(slot), .wdata({neighbor, weight}),
		.raddr(j_q[SW-1:0]), .rdata(edge_rdata)
	);
	swm_ram #(.DW(VW+WW), .DEPTH(SUIT_DEPTH)) u_suit (
		.clk(clk), .we(suit_we), .waddr(suit_waddr), .wdata(suit_wdata),
		.raddr(suit_raddr), .rdata(suit_rdata)
	);

	// per-slot candidate test (suitor data of ey_q is on s_sv/s_sw)
	logic take;
	always_comb begin
		take = 1'b1;
		if (found_q && (ew_q < best_q)) take = 1'b0;
		if (ew_q < s_sw) take = 1'b0;
		if (found_q && (ew_q == best_q) && (ey_q < partner_q)) take = 1'b0;
		if ((ew_q == s_sw) && (cur_q < s_sv)) take = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			run_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			x_q <= '0; cur_q <= '0; qv_q <= '0; j_q <= '0; end_q <= '0;
			found_q <= 1'b0; best_q <= '0; bsw_q <= '0; ew_q <= '0;
			partner_q <= '0; bsv_q <= '0; ey_q <= '0;
			status_q <= STAT_OK; suitor_q <= '0; sweight_q <= '0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (func)
							FN_ROW, FN_EDGE: begin
								status_q    <= (func == FN_ROW && !row_ok) ? STAT_ERR : STAT_OK;
								suitor_q    <= '0;
								sweight_q   <= '0;
							end
							FN_RUN: begin
								clr_q      <= '0;
								run_pend_q <= 1'b1;
								state_q    <= S_CLR;
							end
							default: begin
								if (!q_ok) begin
									status_q    <= STAT_ERR;
									suitor_q    <= '0;
									sweight_q   <= '0;
								end else begin
									qv_q    <= vertex[VW-1:0];
									state_q <= S_QRY;
								end
							end
						endcase
					end
				end
				S_CLR: begin
					clr_q <= clr_q + VW'(1);
					if (clr_q == VW'(SUIT_DEPTH - 1)) begin
						if (!run_pend_q) begin
							state_q <= S_IDLE;
						end else if (vc_q == '0) begin
							state_q <= S_DONE;
						end else begin
							x_q     <= VW'(1);
							cur_q   <= VW'(1);
							state_q <= S_ROW0;
						end
						run_pend_q <= 1'b0;
					end
				end
				S_ROW0: state_q <= S_ROW1;
				S_ROW1: begin
					j_q     <= row_rdata;
					found_q <= 1'b0;
					best_q  <= '0;
					partner_q <= '0;
					state_q <= S_ROW2;
				end
				S_ROW2: begin
					end_q   <= row_rdata;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if ((j_q < end_q) && (j_q < OW'(MAX_SLOTS))) state_q <= S_EWAIT;
					else state_q <= S_PROP;
				end
				S_EWAIT: begin
					ey_q <= e_y;
					ew_q <= e_w;
					if (e_y == '0 || e_y > vc_q) begin
						j_q     <= j_q + OW'(1);
						state_q <= S_EDGE;
					end else begin
						state_q <= S_SWAIT;
					end
				end
				S_SWAIT: begin
					if (take) begin
						found_q   <= 1'b1;
						best_q    <= ew_q;
						partner_q <= ey_q;
						bsw_q     <= s_sw;
						bsv_q     <= s_sv;
					end
					j_q     <= j_q + OW'(1);
					state_q <= S_EDGE;
				end
				S_PROP: begin
					if (win && bsv_q != '0) begin
						cur_q   <= bsv_q;   // displaced suitor tries again
						state_q <= S_ROW0;
					end else if (x_q == vc_q) begin
						state_q <= S_DONE;
					end else begin
						x_q     <= x_q + VW'(1);
						cur_q   <= x_q + VW'(1);
						state_q <= S_ROW0;
					end
				end
				S_QRY: begin
					if (out_free) begin
						status_q    <= STAT_OK;
						suitor_q    <= s_sv;
						sweight_q   <= s_sw;
						state_q     <= S_IDLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						status_q    <= STAT_OK;
						suitor_q    <= '0;
						sweight_q   <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// suitor RAM is only written by the sweep or an accepted proposal
	a_suit_we: assert property (@(posedge clk) disable iff (!arst_n)
		suit_we |-> (state_q == S_CLR || state_q == S_PROP))
		else $error("suitor write outside sweep/proposal");
	// a stored proposal always has a valid partner (a win already needs a nonzero weight)
	a_prop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROP && win) |-> (partner_q != '0 && partner_q <= vc_q))
		else $error("bad proposal partner");
	// an accepted beat is never lost: afterwards the block is busy or holds a reply
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE || out_valid_q))
		else $error("beat lost");
endmodule

// ----- tb/swm_checker.sv -----
`timescale 1ns / 100ps
// Result checker for suitor_weighted_matching: mirrors graph and suitor stores,
// predicts every reply beat and compares it. Depends on swm_pkg.
module swm_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	input  logic                   pready,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  logic [1:0]             func,
	input  logic [swm_pkg::XW-1:0] vertex,
	input  logic [swm_pkg::OW-1:0] offset,
	input  logic [swm_pkg::SW-1:0] slot,
	input  logic [swm_pkg::VW-1:0] neighbor,
	input  logic [swm_pkg::WW-1:0] weight,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   status,
	input  logic [swm_pkg::VW-1:0] suitor,
	input  logic [swm_pkg::WW-1:0] suitor_weight,
	output int                     mismatches,
	output int                     pending
);
	import swm_pkg::*;

	typedef struct packed {
		logic          status;
		logic [VW-1:0] suitor;
		logic [WW-1:0] weight;
	} reply_t;

	reply_t        replies_due[$];
	logic [VW-1:0] vcount;
	logic [OW-1:0] row_off [0:ROW_DEPTH-1];
	logic [VW-1:0] nbr_id [0:MAX_SLOTS-1];
	logic [WW-1:0] edge_w [0:MAX_SLOTS-1];
	logic [VW-1:0] suitor_of [0:SUIT_DEPTH-1];
	logic [WW-1:0] suitor_w [0:SUIT_DEPTH-1];

	initial begin
		mismatches = 0;
		pending = 0;
		vcount = '0;
		foreach (row_off[i]) row_off[i] = '0;
		foreach (nbr_id[i]) begin
			nbr_id[i] = '0;
			edge_w[i] = '0;
		end
		foreach (suitor_of[i]) begin
			suitor_of[i] = '0;
			suitor_w[i] = '0;
		end
	end

	// sequential suitor pass; displaced suitors rescan their own list
	task automatic compute_matching();
		int n, x, cur, j, e, y, partner, old;
		bit more, found;
		logic [WW-1:0] best, w;
		n = vcount;
		foreach (suitor_of[i]) begin
			suitor_of[i] = '0;
			suitor_w[i] = '0;
		end
		for (x = 1; x <= n; x++) begin
			cur = x;
			more = 1;
			while (more) begin
				found = 0;
				best = '0;
				partner = 0;
				j = row_off[cur];
				e = row_off[cur + 1];
				more = 0;
				for (; j < e && j < MAX_SLOTS; j++) begin
					y = nbr_id[j];
					w = edge_w[j];
					if (y == 0 || y > n) continue;
					if (found && w < best) continue;
					if (w < suitor_w[y]) continue;
					if (found && w == best && y < partner) continue;
					if (w == suitor_w[y] && cur < int'(suitor_of[y])) continue;
					found = 1;
					best = w;
					partner = y;
				end
				if (found && best > 0 && (best > suitor_w[partner] ||
						(best == suitor_w[partner] && cur > int'(suitor_of[partner])))) begin
					old = suitor_of[partner];
					suitor_of[partner] = cur[VW-1:0];
					suitor_w[partner] = best;
					if (old != 0) begin
						cur = old;
						more = 1;
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t r, exp_r;
		if (!arst_n) begin
			vcount = '0;
			replies_due.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 3'd0)
				vcount = pwdata[VW-1:0];
			if (in_valid && !in_stall) begin
				r = '0;
				case (func)
					FN_ROW: begin
						if (vertex > MAX_VERTICES + 1 || offset > MAX_SLOTS) r.status = STAT_ERR;
						else row_off[vertex] = offset;
					end
					FN_EDGE: begin
						nbr_id[slot] = neighbor;
						edge_w[slot] = weight;
					end
					FN_RUN: compute_matching();
					default: begin
						if (vertex == 0 || vertex > vcount) r.status = STAT_ERR;
						else begin
							r.suitor = suitor_of[vertex];
							r.weight = suitor_w[vertex];
						end
					end
				endcase
				replies_due.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reply beat with nothing outstanding", $realtime);
				end else begin
					exp_r = replies_due.pop_front();
					if (exp_r.status !== status || exp_r.suitor !== suitor ||
							exp_r.weight !== suitor_weight) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: reply mismatch exp st=%0d s=%0d w=%h got st=%0d s=%0d w=%h",
								$realtime, exp_r.status, exp_r.suitor, exp_r.weight,
								status, suitor, suitor_weight);
					end
				end
			end
			pending = replies_due.size();
		end
	end
endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the suitor matching testbench: clock, reset, APB and beat stimulus.
// Depends on swm_pkg, suitor_weighted_matching and swm_checker.
module testbench;
	import swm_pkg::*;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;
	logic          in_valid = 1'b0, in_stall;
	logic [1:0]    func = FN_ROW;
	logic [XW-1:0] vertex = '0;
	logic [OW-1:0] offset = '0;
	logic [SW-1:0] slot = '0;
	logic [VW-1:0] neighbor = '0;
	logic [WW-1:0] weight = '0;
	logic          out_valid, out_stall = 1'b0;
	logic          status;
	logic [VW-1:0] suitor;
	logic [WW-1:0] suitor_weight;
	int            mismatches, pending;

	int beats_sent = 0;   // accepted input beats
	int runs_done = 0;
	int graph_edges = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;   // random gaps and stalls; off near the end

	suitor_weighted_matching dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .vertex(vertex), .offset(offset), .slot(slot),
		.neighbor(neighbor), .weight(weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .suitor(suitor), .suitor_weight(suitor_weight)
	);

	swm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .vertex(vertex), .offset(offset), .slot(slot),
		.neighbor(neighbor), .weight(weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .suitor(suitor), .suitor_weight(suitor_weight),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure in random bursts while idle_on is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// present one beat, hold it until taken, then maybe leave a gap
	task automatic send(input logic [1:0] f, input logic [XW-1:0] v, input logic [OW-1:0] o,
			input logic [SW-1:0] s, input logic [VW-1:0] nb, input logic [WW-1:0] w);
		in_valid <= 1'b1;
		func <= f;
		vertex <= v;
		offset <= o;
		slot <= s;
		neighbor <= nb;
		weight <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		if (func == FN_RUN) runs_done++;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// drain all replies; then wait on so the block is surely idle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register write with junk above the 10 used bits
	task automatic set_vcount(input int n);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'd0;
		pwdata <= {22'($urandom_range(0, 32'h3F_FFFF)), n[VW-1:0]};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [WW-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			default: return $urandom_range(1, 4) << 16;   // ties are common
		endcase
	endfunction

	// compressed lists for vertices 1..n in a contiguous slot window
	task automatic load_graph(input int n, input int max_deg);
		int deg [1:64];
		int total, base, off, k, nb;
		total = 0;
		for (int v = 1; v <= n; v++) begin
			deg[v] = $urandom_range(0, max_deg);
			total += deg[v];
		end
		base = ($urandom_range(0, 3) == 0) ? MAX_SLOTS - total
			: $urandom_range(0, MAX_SLOTS - total);
		off = base;
		for (int v = 1; v <= n; v++) begin
			// an empty list may be given a start above its end
			if (deg[v] == 0 && off + 5 <= MAX_SLOTS && $urandom_range(0, 2) == 0)
				send(FN_ROW, XW'(v), OW'(off + $urandom_range(1, 5)), '0, '0, '0);
			else
				send(FN_ROW, XW'(v), OW'(off), '0, '0, '0);
			for (k = 0; k < deg[v]; k++) begin
				case ($urandom_range(0, 11))
					0: nb = 0;
					1: nb = $urandom_range(n + 1, 1023);
					default: nb = $urandom_range(1, n);
				endcase
				send(FN_EDGE, '0, '0, SW'(off + k), VW'(nb), pick_weight());
				graph_edges++;
			end
			off += deg[v];
		end
		send(FN_ROW, XW'(n + 1), OW'(off), '0, '0, '0);
	endtask

	task automatic noise_beat();
		case ($urandom_range(0, 2))
			0: send(FN_ROW, XW'($urandom_range(MAX_VERTICES + 2, 2047)), OW'($urandom()),
				'0, '0, '0);
			1: send(FN_ROW, XW'($urandom_range(0, MAX_VERTICES + 1)),
				OW'($urandom_range(MAX_SLOTS + 1, 16383)), '0, '0, '0);
			default: send(FN_QUERY, XW'($urandom_range(0, 2047)), OW'($urandom()),
				SW'($urandom()), VW'($urandom()), $urandom());
		endcase
	endtask

	initial begin
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty graph, range errors, a small tie-heavy graph
		send(FN_QUERY, 0, '0, '0, '0, '0);
		send(FN_QUERY, 1, '0, '0, '0, '0);
		send(FN_ROW, XW'(MAX_VERTICES + 2), 0, '0, '0, '0);
		send(FN_ROW, 0, OW'(MAX_SLOTS + 1), '0, '0, '0);
		send(FN_ROW, 2047, 16383, '0, '0, '0);
		send(FN_RUN, '0, '0, '0, '0, '0);
		set_vcount(3);
		send(FN_ROW, 1, 8189, '0, '0, '0);
		send(FN_EDGE, '0, '0, 8189, 2, 32'h0001_0000);
		send(FN_ROW, 2, 8190, '0, '0, '0);
		send(FN_EDGE, '0, '0, 8190, 3, 32'h0001_0000);
		send(FN_ROW, 3, 8191, '0, '0, '0);
		send(FN_EDGE, '0, '0, 8191, 1, 32'hFFFF_FFFF);
		send(FN_ROW, 4, OW'(MAX_SLOTS), '0, '0, '0);
		send(FN_RUN, '0, '0, '0, '0, '0);
		for (int v = 0; v <= 4; v++) send(FN_QUERY, XW'(v), '0, '0, '0, '0);
		set_vcount(MAX_VERTICES);
		send(FN_QUERY, XW'(MAX_VERTICES), '0, '0, '0, '0);
		send(FN_QUERY, XW'(MAX_VERTICES + 1), '0, '0, '0, '0);
		set_vcount(0);
		send(FN_RUN, '0, '0, '0, '0, '0);
		send(FN_QUERY, 1, '0, '0, '0, '0);

		// random phases: load, run, query, with noise mixed in
		while (beats_sent < 1900) begin
			if (beats_sent > 1650) idle_on = 1'b0;
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 16);
			set_vcount(n);
			load_graph(n, (n > 32) ? 3 : 5);
			repeat ($urandom_range(0, 4)) noise_beat();
			send(FN_RUN, XW'($urandom()), OW'($urandom()), SW'($urandom()),
				VW'($urandom()), $urandom());
			for (int v = 0; v <= n + 1; v++) begin
				send(FN_QUERY, XW'(v), '0, '0, '0, '0);
				if ($urandom_range(0, 9) == 0) noise_beat();
			end
			if ($urandom_range(0, 3) == 0) begin
				set_vcount($urandom_range(0, 1) ? MAX_VERTICES : 0);
				repeat (3) send(FN_QUERY, XW'($urandom_range(0, 2047)), '0, '0, '0, '0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d beats, %0d matching runs over %0d loaded edges.",
			beats_sent, runs_done, graph_edges);
		$display("Reply mismatches counted: %0d", mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("Timeout: replies still outstanding or input held off");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
